[design/apr_pkg.sv]
package apr_pkg;

  // table geometry
  localparam int SLOTS     = 4;
  localparam int PAGE_BITS = 20;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // fixed field widths
  localparam int IN_PAGE_W  = 20;
  localparam int OUT_IDX_W  = 2;
  localparam int AGE_W      = 32;
  localparam int FAULT_W    = 32;
  localparam int REF_POS    = 30;

  localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(1) << (AGE_W - 1);

  // input mode codes
  typedef enum logic {
    MODE_ACCESS = 1'b0,
    MODE_TICK   = 1'b1
  } mode_t;

  typedef logic [SLOT_W-1:0]             slot_idx_t;
  typedef logic [AGE_W-1:0]              age_t;
  typedef logic [SLOTS-1:0][AGE_W-1:0]   age_vec_t;
  typedef logic [SLOTS-1:0][PAGE_BITS-1:0] page_vec_t;

  // one aging step of a counter
  function automatic age_t age_step(input age_t c, input logic ref_bit);
    age_t shifted;
    shifted = (c == AGE_TOP) ? '0 : (c >> 1);
    return shifted + (AGE_W'(ref_bit) << REF_POS);
  endfunction

endpackage

[design/aging_page_replacement.sv]
// Aging page replacement table.
// Timing: an accepted beat is captured in the input register, and the result strobe
// and the result come from the result register, which is loaded from it.
// Throughput: one beat per cycle; busy stays low, the table is updated in a
// single pass between the input register and the result register.
// Reset (rst_n low, synchronous): all slots hold page 0 with zero counters and
// clear referenced bits, fault count is zero. The receiver cannot stall.
module aging_page_replacement
  import apr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_mode,
  input  logic [IN_PAGE_W-1:0]   in_page_number,
  output logic                   out_valid,
  output logic                   out_hit,
  output logic [OUT_IDX_W-1:0]   out_slot_index,
  output logic [FAULT_W-1:0]     out_fault_total
);

  // input register
  logic                 in_valid_r;
  mode_t                mode_r;
  logic [PAGE_BITS-1:0] page_r;

  // slot table
  page_vec_t            page_r_tbl;
  age_vec_t             age_r;
  logic [SLOTS-1:0]     ref_r;
  logic [FAULT_W-1:0]   fault_r;

  // result register
  logic                 out_valid_r;
  logic                 hit_r;
  logic [OUT_IDX_W-1:0] slot_r;

  page_vec_t            page_nxt;
  age_vec_t             age_nxt;
  logic [SLOTS-1:0]     ref_nxt;
  logic [FAULT_W-1:0]   fault_nxt;
  logic                 hit_nxt;
  logic [OUT_IDX_W-1:0] slot_nxt;

  logic                 found;
  slot_idx_t            hit_idx;
  slot_idx_t            victim;
  slot_idx_t            sel_idx;

  assign busy = 1'b0;

  // capture the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_t'(in_mode);
    page_r <= PAGE_BITS'(in_page_number);
  end

  // lowest matching slot
  always_comb begin
    found   = 1'b0;
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (page_r_tbl[i] == page_r) begin
        found   = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  apr_victim_sel u_victim (
    .ages   (age_r),
    .victim (victim)
  );

  assign sel_idx = found ? hit_idx : victim;

  // table update for the registered beat
  always_comb begin
    page_nxt  = page_r_tbl;
    age_nxt   = age_r;
    ref_nxt   = ref_r;
    fault_nxt = fault_r;
    hit_nxt   = 1'b0;
    slot_nxt  = '0;
    if (in_valid_r) begin
      unique case (mode_r)
        MODE_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            age_nxt[i] = age_step(age_r[i], ref_r[i]);
          end
          ref_nxt = '0;
        end
        MODE_ACCESS: begin
          hit_nxt  = found;
          slot_nxt = OUT_IDX_W'(sel_idx);
          ref_nxt[sel_idx] = 1'b1;
          if (!found) begin
            page_nxt[sel_idx] = page_r;
            age_nxt[sel_idx]  = AGE_TOP;
            if (fault_r != '1) begin
              fault_nxt = fault_r + FAULT_W'(1);
            end
          end
        end
        default: begin
          ref_nxt = ref_r;
        end
      endcase
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r_tbl <= '0;
      age_r      <= '0;
      ref_r      <= '0;
      fault_r    <= '0;
    end else begin
      page_r_tbl <= page_nxt;
      age_r      <= age_nxt;
      ref_r      <= ref_nxt;
      fault_r    <= fault_nxt;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    hit_r  <= hit_nxt;
    slot_r <= slot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_slot_index  = slot_r;
  assign out_fault_total = fault_r;

endmodule

[design/apr_victim_sel.sv]
module apr_victim_sel
  import apr_pkg::*;
(
  input  age_vec_t  ages,
  output slot_idx_t victim
);

  // lowest-indexed slot holding the smallest counter
  always_comb begin
    age_t best;
    best   = ages[0];
    victim = '0;
    for (int i = 1; i < SLOTS; i++) begin
      if (ages[i] < best) begin
        best   = ages[i];
        victim = SLOT_W'(i);
      end
    end
  end

endmodule

[verif/apr_checker.sv]
module apr_checker
  import apr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_mode,
  input  logic [IN_PAGE_W-1:0] in_page_number,
  input  logic                 out_valid,
  input  logic                 out_hit,
  input  logic [OUT_IDX_W-1:0] out_slot_index,
  input  logic [FAULT_W-1:0]   out_fault_total,
  output int                   mismatches,
  output int                   outstanding
);

  // one expected result beat
  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] slot;
    logic [FAULT_W-1:0]   faults;
  } lookup_t;

  // shadow copy of the page table
  logic [PAGE_BITS-1:0] page_tbl [SLOTS];
  age_t                 age_tbl  [SLOTS];
  logic                 ref_tbl  [SLOTS];
  logic [FAULT_W-1:0]   fault_cnt;

  lookup_t lookups_due [$];
  int      errs = 0;

  // update the shadow table for one beat and return the lookup it should give
  function automatic lookup_t lookup_page(input mode_t op, input logic [IN_PAGE_W-1:0] pg);
    lookup_t              res;
    logic [PAGE_BITS-1:0] key;
    bit                   found;
    int                   victim;
    res = '0;
    // tick: age every counter, then drop all referenced bits
    if (op == MODE_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        age_tbl[i] = ((age_tbl[i] == AGE_TOP) ? age_t'(0) : (age_tbl[i] >> 1))
                     + (age_t'(ref_tbl[i]) << REF_POS);
        ref_tbl[i] = 1'b0;
      end
      res.faults = fault_cnt;
      return res;
    end
    key    = pg[PAGE_BITS-1:0];
    found  = 1'b0;
    victim = 0;
    // lowest matching slot wins
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && page_tbl[i] == key) begin
        found  = 1'b1;
        victim = i;
      end
    end
    if (found) begin
      ref_tbl[victim] = 1'b1;
      res.hit = 1'b1;
    end else begin
      if (fault_cnt != '1) fault_cnt = fault_cnt + FAULT_W'(1);
      // lowest index among the smallest counters is refilled
      victim = 0;
      for (int i = 1; i < SLOTS; i++) begin
        if (age_tbl[i] < age_tbl[victim]) victim = i;
      end
      page_tbl[victim] = key;
      age_tbl[victim]  = AGE_TOP;
      ref_tbl[victim]  = 1'b1;
    end
    res.slot   = OUT_IDX_W'(victim);
    res.faults = fault_cnt;
    return res;
  endfunction

  // predict on accepted input beats, compare result beats in order
  always @(posedge clk) begin
    lookup_t want;
    lookup_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        page_tbl[i] = '0;
        age_tbl[i]  = '0;
        ref_tbl[i]  = 1'b0;
      end
      fault_cnt = '0;
      lookups_due.delete();
    end else begin
      if (out_valid) begin
        if (lookups_due.size() == 0) begin
          $error("result beat with no lookup pending");
          errs++;
        end else begin
          want = lookups_due.pop_front();
          if (out_hit !== want.hit) begin
            $error("out_hit: expected %0d, got %0d", want.hit, out_hit);
            errs++;
          end
          if (out_slot_index !== want.slot) begin
            $error("out_slot_index: expected %0d, got %0d", want.slot, out_slot_index);
            errs++;
          end
          if (out_fault_total !== want.faults) begin
            $error("out_fault_total: expected %0d, got %0d", want.faults, out_fault_total);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        fresh = lookup_page(mode_t'(in_mode), in_page_number);
        lookups_due = {lookups_due, fresh};
      end
    end
    outstanding <= lookups_due.size();
    mismatches  <= errs;
  end

endmodule

[verif/tb.sv]
module tb;
  import apr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_BEATS  = 1150;
  localparam int POOL_SIZE   = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 in_mode = MODE_ACCESS;
  logic [IN_PAGE_W-1:0] in_page_number = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_hit;
  logic [OUT_IDX_W-1:0] out_slot_index;
  logic [FAULT_W-1:0]   out_fault_total;
  int                   mismatches;
  int                   outstanding;
  int unsigned          cycles = 0;

  logic [IN_PAGE_W-1:0] page_pool [POOL_SIZE];

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  aging_page_replacement uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot_index (out_slot_index),
    .out_fault_total(out_fault_total)
  );

  apr_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_page_number (in_page_number),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_slot_index (out_slot_index),
    .out_fault_total(out_fault_total),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // idle for the given gap, then hold one beat until it is taken
  task automatic issue(input mode_t op, input logic [IN_PAGE_W-1:0] pg, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_mode        <= op;
    in_page_number <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every pending lookup has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int    gap;
    int    pick;
    bit    burst;
    mode_t op;
    logic [IN_PAGE_W-1:0] pg;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: page zero after reset, ties, multiple matches, extremes
    issue(MODE_ACCESS, 20'h00000, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'hFFFFF, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h00000, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'hFFFFF, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h12345, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'hABCDE, $urandom_range(0, 13));
    issue(MODE_TICK,   20'h00000, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h55555, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'hAAAAA, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h12345, $urandom_range(0, 13));
    issue(MODE_TICK,   20'h00000, 0);
    issue(MODE_TICK,   20'hFFFFF, 0);
    issue(MODE_ACCESS, 20'hFFFFF, 0);
    issue(MODE_ACCESS, 20'h00001, 0);
    issue(MODE_TICK,   20'h5A5A5, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h80000, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h7FFFF, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h80000, $urandom_range(0, 13));
    issue(MODE_TICK,   20'h00000, $urandom_range(0, 13));
    issue(MODE_ACCESS, 20'h00000, $urandom_range(0, 13));
    drain();

    // random: a small working set of pages so hits and evictions both happen
    burst = 1'b0;
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 100 == 0) begin
        for (int k = 0; k < POOL_SIZE; k++) page_pool[k] = IN_PAGE_W'($urandom);
      end
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (n % 250 == 125) drain();
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        op = MODE_TICK;
        pg = IN_PAGE_W'($urandom);
      end else if (pick < 88) begin
        op = MODE_ACCESS;
        pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        op = MODE_ACCESS;
        pg = IN_PAGE_W'($urandom);
      end
      gap = burst ? 0 : $urandom_range(0, 13);
      issue(op, pg, gap);
    end

    // wind down
    drain();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
